// ===== hw/rtl/efws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efws_pkg
// Shared types and constants for the earliest-free worker scheduler.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int MAX_WORKERS_DEF = 16;

  localparam int DUR_W  = 32;   // job duration
  localparam int TIME_W = 63;   // worker free time / start time
  localparam int IDX_W  = 4;    // reported worker index
  localparam int CFG_W  = 5;    // active_workers register
  localparam int ADDR_W = 3;    // APB byte address
  localparam int DATA_W = 32;   // APB data

  localparam logic [CFG_W-1:0]    ACTIVE_RST = 5'd16;
  // word index of the active_workers register
  localparam logic [ADDR_W-3:0]   REG_ACTIVE = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic idx_clr;   // restart the shared index counter
    logic load;      // latch job duration, restart counter
    logic scan_rd;   // read free time at counter, advance
    logic clr_wr;    // write zero at counter, advance
    logic commit;    // update chosen worker, emit result
  } efws_cmd_t;

  typedef struct packed {
    logic scan_last;   // counter at last active worker
    logic clear_last;  // counter at last storage entry
  } efws_sts_t;

endpackage : efws_pkg
`default_nettype wire

// ===== hw/rtl/earliest_free_worker_scheduler_top.sv =====
`default_nettype none
// After a request is accepted, ST_SCAN reads the free times of the N active workers, then
//   ST_LAST and ST_COMMIT follow; done is registered from the commit. A new request
//   is taken only once idle again; the free-time memory is scanned one word per cycle.
// Reset and each active_workers write run a clearing pass over all MAX_WORKERS entries,
//   busy high throughout. Results last one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// Assigns each job to the worker free earliest and reports its start time.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_top import efws_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DUR_W-1:0]  job_duration,
  output logic              done,
  output logic [IDX_W-1:0]  worker_index,
  output logic [TIME_W-1:0] start_time,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] active_workers;
  logic             reg_hit;
  logic             cfg_wr;
  efws_cmd_t        cmd;
  efws_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_ACTIVE);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? {{(DATA_W - CFG_W){1'b0}}, active_workers} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACTIVE_RST;
    end else if (cfg_wr) begin
      active_workers <= pwdata[CFG_W-1:0];
    end
  end

  efws_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  efws_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .active_workers (active_workers),
    .job_duration   (job_duration),
    .done           (done),
    .worker_index   (worker_index),
    .start_time     (start_time)
  );

endmodule : earliest_free_worker_scheduler_top
`default_nettype wire

// ===== hw/rtl/efws_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efws_ctrl
// Sequencer: clearing pass, request accept, free-time scan and commit.
// ----------------------------------------------------------------------------
module efws_ctrl import efws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cfg_wr,
  input  efws_sts_t sts,
  output efws_cmd_t cmd,
  output logic      busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        // last read word is compared this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a new worker count starts a new batch: wipe all free times
    if (cfg_wr) begin
      cmd        = '0;
      cmd.idx_clr = 1'b1;
      state_next = ST_CLEAR;
    end
  end

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan_rd, cmd.clr_wr, cmd.commit}))
    else $error("efws_ctrl: more than one datapath command");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_wr) |=> (state == ST_SCAN))
    else $error("efws_ctrl: accepted request did not start a scan");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && sts.scan_last && !cfg_wr) |=> (state == ST_LAST))
    else $error("efws_ctrl: scan overran the last worker");

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !cfg_wr) |=> (!cmd.commit && state == ST_IDLE))
    else $error("efws_ctrl: commit not followed by idle");

endmodule : efws_ctrl
`default_nettype wire

// ===== hw/rtl/efws_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efws_dp
// Free-time memory, sequential minimum search and saturating update.
// ----------------------------------------------------------------------------
module efws_dp import efws_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  efws_cmd_t         cmd,
  output efws_sts_t         sts,
  input  logic [CFG_W-1:0]  active_workers,
  input  logic [DUR_W-1:0]  job_duration,
  output logic              done,
  output logic [IDX_W-1:0]  worker_index,
  output logic [TIME_W-1:0] start_time
);

  localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [TIME_W-1:0]   mem [MAX_WORKERS];
  logic [IW-1:0]       idx;
  logic [IW-1:0]       cmp_idx;
  logic [IW-1:0]       best_idx;
  logic [IW-1:0]       last_idx;
  logic [IW-1:0]       wr_addr;
  logic [TIME_W-1:0]   rd_data;
  logic [TIME_W-1:0]   best_time;
  logic [TIME_W-1:0]   wr_data;
  logic [DUR_W-1:0]    dur;
  logic                cmp_valid;
  logic                wr_en;
  logic [TIME_W:0]     sum;
  logic [IW+IDX_W-1:0] best_wide;

  // effective worker count minus one (0 reads as 1, clipped to MAX_WORKERS)
  always_comb begin
    if (active_workers == '0) begin
      last_idx = '0;
    end else if (int'(active_workers) > MAX_WORKERS) begin
      last_idx = IW'(MAX_WORKERS - 1);
    end else begin
      last_idx = IW'(active_workers - 5'd1);
    end
  end

  assign sts.scan_last  = (idx == last_idx);
  assign sts.clear_last = (idx == IW'(MAX_WORKERS - 1));

  assign sum       = {1'b0, best_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
  assign wr_en     = cmd.commit | cmd.clr_wr;
  assign wr_addr   = cmd.commit ? best_idx : idx;
  assign wr_data   = cmd.commit ? (sum[TIME_W] ? '1 : sum[TIME_W-1:0]) : '0;
  assign best_wide = {{IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cmd.idx_clr || cmd.load) begin
        idx <= '0;
      end else if (cmd.scan_rd || cmd.clr_wr) begin
        idx <= idx + 1'b1;
      end
      cmp_valid <= cmd.scan_rd;
      done      <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur <= job_duration;
    end
    cmp_idx <= idx;
    // strict less-than keeps the lowest index on ties
    if (cmp_valid && (cmp_idx == '0 || rd_data < best_time)) begin
      best_idx  <= cmp_idx;
      best_time <= rd_data;
    end
    if (cmd.commit) begin
      worker_index <= best_wide[IDX_W-1:0];
      start_time   <= best_time;
    end
  end

endmodule : efws_dp
`default_nettype wire
